>>> rtl/cli_pkg.sv
// Shared types, constants and helpers for the clamped linear interpolator.
package cli_pkg;

    // Table geometry and data widths
    localparam int SAMPLE_DEPTH = 256;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    localparam int DATA_W       = 32;
    localparam int INDEX_W      = 8;
    localparam int COUNT_W      = 9;
    localparam int WEIGHT_W     = 16;
    localparam int STEP_W       = $clog2(WEIGHT_W);
    localparam int ENTRY_W      = 3 * DATA_W;
    // Shared adder width: 33-bit differences plus a sign bit
    localparam int ALU_W        = DATA_W + 2;
    // Signed difference times unsigned weight
    localparam int PROD_W       = (DATA_W + 1) + (WEIGHT_W + 1);

    // Operation codes of an input item
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Clamp codes of a result item
    localparam logic [1:0] CLAMP_INSIDE = 2'd0;
    localparam logic [1:0] CLAMP_FIRST  = 2'd1;
    localparam logic [1:0] CLAMP_LAST   = 2'd2;

    // Control of the shared adder
    typedef struct packed {
        logic sub;       // a - b when set, a + b + carry_in otherwise
        logic carry_in;
    } alu_ctrl_t;

    // Sign-extend a data word to adder width
    function automatic logic [ALU_W-1:0] sext(input logic [DATA_W-1:0] v);
        sext = {{(ALU_W - DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // Table entry layout: {second value, first value, position}
    function automatic logic [DATA_W-1:0] entry_pos(input logic [ENTRY_W-1:0] e);
        entry_pos = e[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] entry_val(input logic [ENTRY_W-1:0] e,
                                                    input logic second);
        entry_val = second ? e[3*DATA_W-1:2*DATA_W] : e[2*DATA_W-1:DATA_W];
    endfunction

endpackage

>>> rtl/cli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/cli_alu.sv
// Shared adder/subtractor used for compares, differences and divide steps.
module cli_alu (
    input  logic [cli_pkg::ALU_W-1:0] a,
    input  logic [cli_pkg::ALU_W-1:0] b,
    input  cli_pkg::alu_ctrl_t        ctrl,
    output logic [cli_pkg::ALU_W-1:0] res
);

    logic [cli_pkg::ALU_W-1:0] b_op;
    logic                      cin;

    // Subtract as a plus inverted b plus one
    always_comb
    begin
        b_op = ctrl.sub ? ~b : b;
        cin  = ctrl.sub | ctrl.carry_in;
        res  = a + b_op + {{(cli_pkg::ALU_W - 1){1'b0}}, cin};
    end

endmodule

>>> rtl/clamped_linear_interpolator.sv
// Top level: sample table, sequencer and datapath of the linear interpolator.
//
// Usage. The input channel (in_valid/in_ready) carries load and query items.
// A load (op = 0) writes position, value_x and value_y into table entry index
// in the cycle it is accepted and gives no result; the block is ready again
// in the next cycle. A query (op = 1) gives one result item on the output
// channel (out_valid/out_ready): the chosen component interpolated at the
// query position, with clamp_code telling inside, first or last.
// An inside result comes after a linear scan over the table (one table read
// per cycle) up to the bracket end found and a 16-step restoring divide
// through the shared adder; a first-sample or last-sample clamp skips both.
// The block takes no new item while a query is in flight.
// sample_count is to be written through cfg_write/cfg_data only while idle; the block itself does not enforce this.
// Reset clears the sequencer, drops out_valid and sets sample_count to 1;
// table contents are undefined until loaded. A stalled receiver holds the
// result in the output register; loads are still taken meanwhile, and the
// next query runs and waits at its end until the held result is taken.
module clamped_linear_interpolator (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration
    input  logic                             cfg_write,
    input  logic [cli_pkg::COUNT_W-1:0]      cfg_data,
    // Input channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             op,
    input  logic [cli_pkg::INDEX_W-1:0]      index,
    input  logic signed [cli_pkg::DATA_W-1:0] position,
    input  logic signed [cli_pkg::DATA_W-1:0] value_x,
    input  logic signed [cli_pkg::DATA_W-1:0] value_y,
    input  logic                             component,
    // Output channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [cli_pkg::DATA_W-1:0] result_value,
    output logic [1:0]                       clamp_code
);

    localparam int DW = cli_pkg::DATA_W;
    localparam int AW = cli_pkg::ADDR_W;
    localparam int WW = cli_pkg::WEIGHT_W;
    localparam int XW = cli_pkg::ALU_W;
    localparam int PW = cli_pkg::PROD_W;
    localparam int SW = cli_pkg::STEP_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP_FIRST,
        ST_CMP_LAST,
        ST_SCAN,
        ST_NUM,
        ST_DEN,
        ST_DIV,
        ST_DIFF,
        ST_MUL,
        ST_ADD,
        ST_FIN
    } state_t;

    state_t                       state_reg;
    logic [cli_pkg::COUNT_W-1:0]  count_reg;
    logic [DW-1:0]                q_reg;
    logic                         comp_reg;
    logic [AW-1:0]                last_reg;
    logic [AW-1:0]                k_reg;
    logic [DW-1:0]                p0_reg;
    logic [DW-1:0]                a_reg;
    logic [DW-1:0]                p1_reg;
    logic [DW-1:0]                b_reg;
    logic [DW-1:0]                rem_reg;
    logic [DW-1:0]                den_reg;
    logic [WW-1:0]                quo_reg;
    logic [SW-1:0]                step_reg;
    logic signed [DW:0]           diff_reg;
    logic signed [PW-1:0]         prod_reg;
    logic [DW-1:0]                res_reg;
    logic [1:0]                   code_reg;
    logic                         out_valid_reg;
    logic [DW-1:0]                result_reg;
    logic [1:0]                   clamp_reg;

    logic                         in_accept;
    logic                         fin_fire;
    logic                         ram_we;
    logic [AW-1:0]                ram_raddr;
    logic [cli_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [DW-1:0]                rd_pos;
    logic [DW-1:0]                rd_val;
    logic [XW-1:0]                alu_a;
    logic [XW-1:0]                alu_b;
    cli_pkg::alu_ctrl_t           alu_ctrl;
    logic [XW-1:0]                alu_res;
    logic                         alu_neg;
    logic                         alu_zero;
    logic [31:0]                  n_eff;
    logic [AW-1:0]                last_eff;

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_accept    = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign clamp_code   = clamp_reg;

    // Finished result moves into the output register when it is free
    assign fin_fire = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // Table write on an accepted load, ignored beyond the depth
    assign ram_we = in_accept && (op == cli_pkg::OP_LOAD)
                    && (32'(index) < cli_pkg::SAMPLE_DEPTH);

    cli_ram #(
        .WIDTH(cli_pkg::ENTRY_W),
        .DEPTH(cli_pkg::SAMPLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(AW'(index)),
        .wdata({value_y, value_x, position}),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_pos = cli_pkg::entry_pos(ram_rdata);
    assign rd_val = cli_pkg::entry_val(ram_rdata, comp_reg);

    // Effective sample count: zero reads as one, large counts saturate
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = 32'd1;
        end
        else if (32'(count_reg) > cli_pkg::SAMPLE_DEPTH)
        begin
            n_eff = cli_pkg::SAMPLE_DEPTH;
        end
        else
        begin
            n_eff = 32'(count_reg);
        end
        last_eff = AW'(n_eff - 32'd1);
    end

    // Next table address, issued ahead of use through the registered read port
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:      ram_raddr = '0;
            ST_CMP_FIRST: ram_raddr = last_reg;
            ST_CMP_LAST:  ram_raddr = AW'(1);
            ST_SCAN:      ram_raddr = k_reg + AW'(1);
            default:      ram_raddr = '0;
        endcase
    end

    // Operand selection for the shared adder
    always_comb
    begin
        alu_a    = '0;
        alu_b    = '0;
        alu_ctrl = '{sub: 1'b1, carry_in: 1'b0};
        unique case (state_reg)
            ST_CMP_FIRST, ST_CMP_LAST, ST_SCAN:
            begin
                alu_a = cli_pkg::sext(q_reg);
                alu_b = cli_pkg::sext(rd_pos);
            end
            ST_NUM:
            begin
                alu_a = cli_pkg::sext(q_reg);
                alu_b = cli_pkg::sext(p0_reg);
            end
            ST_DEN:
            begin
                alu_a = cli_pkg::sext(p1_reg);
                alu_b = cli_pkg::sext(p0_reg);
            end
            ST_DIV:
            begin
                alu_a = XW'({rem_reg, 1'b0});
                alu_b = XW'(den_reg);
            end
            ST_DIFF:
            begin
                alu_a = cli_pkg::sext(b_reg);
                alu_b = cli_pkg::sext(a_reg);
            end
            ST_ADD:
            begin
                alu_a    = cli_pkg::sext(a_reg);
                alu_b    = prod_reg[PW-1:WW];
                alu_ctrl = '{sub: 1'b0, carry_in: prod_reg[WW-1]};
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    cli_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .ctrl(alu_ctrl),
        .res (alu_res)
    );

    assign alu_neg  = alu_res[XW-1];
    assign alu_zero = (alu_res == '0);

    // Sequencer, datapath registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= cli_pkg::COUNT_W'(1);
            out_valid_reg <= 1'b0;
            q_reg         <= '0;
            comp_reg      <= 1'b0;
            last_reg      <= '0;
            k_reg         <= '0;
            p0_reg        <= '0;
            a_reg         <= '0;
            p1_reg        <= '0;
            b_reg         <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            quo_reg       <= '0;
            step_reg      <= '0;
            diff_reg      <= '0;
            prod_reg      <= '0;
            res_reg       <= '0;
            code_reg      <= cli_pkg::CLAMP_INSIDE;
            result_reg    <= '0;
            clamp_reg     <= cli_pkg::CLAMP_INSIDE;
        end
        else
        begin
            if (cfg_write)
            begin
                count_reg <= cfg_data;
            end
            // Output valid: set on a handoff, cleared when taken
            if (fin_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && (op == cli_pkg::OP_QUERY))
                    begin
                        q_reg     <= position;
                        comp_reg  <= component;
                        last_reg  <= last_eff;
                        state_reg <= ST_CMP_FIRST;
                    end
                end
                // Entry 0 is on the read port
                ST_CMP_FIRST:
                begin
                    if ((last_reg == '0) || alu_neg || alu_zero)
                    begin
                        res_reg   <= rd_val;
                        code_reg  <= cli_pkg::CLAMP_FIRST;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        p0_reg    <= rd_pos;
                        a_reg     <= rd_val;
                        state_reg <= ST_CMP_LAST;
                    end
                end
                // Last entry is on the read port
                ST_CMP_LAST:
                begin
                    if (!alu_neg)
                    begin
                        res_reg   <= rd_val;
                        code_reg  <= cli_pkg::CLAMP_LAST;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        k_reg     <= AW'(1);
                        state_reg <= ST_SCAN;
                    end
                end
                // Entry k on the read port: find first position above query
                ST_SCAN:
                begin
                    if ((k_reg < last_reg) && !alu_neg)
                    begin
                        p0_reg <= rd_pos;
                        a_reg  <= rd_val;
                        k_reg  <= k_reg + AW'(1);
                    end
                    else
                    begin
                        p1_reg    <= rd_pos;
                        b_reg     <= rd_val;
                        state_reg <= ST_NUM;
                    end
                end
                ST_NUM:
                begin
                    rem_reg   <= alu_res[DW-1:0];
                    state_reg <= ST_DEN;
                end
                ST_DEN:
                begin
                    den_reg   <= alu_res[DW-1:0];
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                // Restoring divide, one weight bit per cycle
                ST_DIV:
                begin
                    if (!alu_neg)
                    begin
                        rem_reg <= alu_res[DW-1:0];
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[DW-2:0], 1'b0};
                    end
                    quo_reg  <= {quo_reg[WW-2:0], !alu_neg};
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == SW'(WW - 1))
                    begin
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF:
                begin
                    diff_reg  <= alu_res[DW:0];
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg  <= diff_reg * $signed({1'b0, quo_reg});
                    state_reg <= ST_ADD;
                end
                // a plus product rounded half up
                ST_ADD:
                begin
                    res_reg   <= alu_res[DW-1:0];
                    code_reg  <= cli_pkg::CLAMP_INSIDE;
                    state_reg <= ST_FIN;
                end
                // Hand the result to the output register once it is free
                ST_FIN:
                begin
                    if (fin_fire)
                    begin
                        result_reg <= res_reg;
                        clamp_reg  <= code_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The scan index stays within the bracket range
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((k_reg != '0) && (k_reg <= last_reg)))
        else $error("scan index outside table range");

    // Divide remainder stays below a nonzero divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ((den_reg != '0) && (rem_reg < den_reg)))
        else $error("divide remainder not below divisor");

    // A finished result is never dropped while the output is held
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_valid_reg && !out_ready) |=> (state_reg == ST_FIN))
        else $error("result left sequencer while output stalled");

    // Shown clamp codes are meaningful
    a_clamp_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (clamp_reg == cli_pkg::CLAMP_INSIDE
                           || clamp_reg == cli_pkg::CLAMP_FIRST
                           || clamp_reg == cli_pkg::CLAMP_LAST))
        else $error("invalid clamp code on output");

endmodule

>>> sim/clamped_linear_interpolator_tb.sv
// Self-checking testbench for the clamped linear interpolator: directed table plus random phases.
`timescale 1ns / 1ps

module clamped_linear_interpolator_tb;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 300;
    localparam int KEEP           = -1;
    localparam bit PREDICT        = 1'b0;
    localparam bit TYPED          = 1'b1;

    // Table layouts for generated phases
    localparam int STYLE_ANY    = -1;
    localparam int STYLE_TIGHT  = 0;
    localparam int STYLE_SPREAD = 1;
    localparam int STYLE_FULL   = 2;

    typedef struct {
        logic        op;
        logic [7:0]  index;
        logic [31:0] position;
        logic [31:0] value_x;
        logic [31:0] value_y;
        logic        component;
        bit          typed;
        logic [31:0] exp_value;
        logic [1:0]  exp_code;
    } item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  code;
    } result_t;

    typedef struct {
        int          new_count;
        logic        op;
        logic [7:0]  index;
        logic [31:0] position;
        logic [31:0] value_x;
        logic [31:0] value_y;
        logic        component;
        bit          typed;
        logic [31:0] exp_value;
        logic [1:0]  exp_code;
    } script_row_t;

    // Block ports
    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              cfg_write    = 1'b0;
    logic [cli_pkg::COUNT_W-1:0]       cfg_data     = '0;
    logic                              in_valid     = 1'b0;
    logic                              in_ready;
    logic                              op           = cli_pkg::OP_LOAD;
    logic [cli_pkg::INDEX_W-1:0]       index        = '0;
    logic signed [cli_pkg::DATA_W-1:0] position     = '0;
    logic signed [cli_pkg::DATA_W-1:0] value_x      = '0;
    logic signed [cli_pkg::DATA_W-1:0] value_y      = '0;
    logic                              component    = 1'b0;
    logic                              out_valid;
    logic                              out_ready    = 1'b0;
    logic signed [cli_pkg::DATA_W-1:0] result_value;
    logic [1:0]                        clamp_code;

    // Shadow of the sample table and the count register
    logic [31:0] tbl_pos [cli_pkg::SAMPLE_DEPTH];
    logic [31:0] tbl_x   [cli_pkg::SAMPLE_DEPTH];
    logic [31:0] tbl_y   [cli_pkg::SAMPLE_DEPTH];
    int unsigned tbl_count = 1;

    // Positions as queued, used to aim generated queries
    logic [31:0] plan_pos [cli_pkg::SAMPLE_DEPTH];

    item_t       queued_items [$];
    result_t     pending_results [$];
    item_t       offered;
    result_t     oldest;
    int unsigned items_queued = 0;
    int unsigned mismatches   = 0;
    int unsigned stall_cycles = 0;
    logic        no_idle      = 1'b0;
    logic        hold_off     = 1'b0;
    logic        pressure_go  = 1'b0;

    // Directed items; a new count is written with the block idle before its row
    script_row_t directed_rows [24] = '{
        // single sample: every query clamps to entry zero
        '{KEEP, cli_pkg::OP_LOAD,  8'd0,   32'h00000000, 32'h7FFFFFFF, 32'h80000000, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_QUERY, 8'd0,   32'h7FFFFFFF, 32'h00000000, 32'h00000000, 1'b0,
          TYPED, 32'h7FFFFFFF, cli_pkg::CLAMP_FIRST},
        '{KEEP, cli_pkg::OP_QUERY, 8'd0,   32'h80000000, 32'h00000000, 32'h00000000, 1'b1,
          TYPED, 32'h80000000, cli_pkg::CLAMP_FIRST},
        '{KEEP, cli_pkg::OP_LOAD,  8'd1,   32'h00010000, 32'h80000000, 32'h7FFFFFFF, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_LOAD,  8'd255, 32'h7FFFFFFF, 32'h12345678, 32'hFFFFFFFF, 1'b1,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        // two samples: both ends, then inside with extreme values
        '{2,    cli_pkg::OP_QUERY, 8'd0,   32'h00000000, 32'h00000000, 32'h00000000, 1'b0,
          TYPED, 32'h7FFFFFFF, cli_pkg::CLAMP_FIRST},
        '{KEEP, cli_pkg::OP_QUERY, 8'd0,   32'h00010000, 32'h00000000, 32'h00000000, 1'b0,
          TYPED, 32'h80000000, cli_pkg::CLAMP_LAST},
        '{KEEP, cli_pkg::OP_QUERY, 8'd0,   32'h7FFFFFFF, 32'h00000000, 32'h00000000, 1'b1,
          TYPED, 32'h7FFFFFFF, cli_pkg::CLAMP_LAST},
        '{KEEP, cli_pkg::OP_QUERY, 8'd0,   32'h00008000, 32'h00000000, 32'h00000000, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_QUERY, 8'd0,   32'h00000001, 32'h00000000, 32'h00000000, 1'b1,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_QUERY, 8'd0,   32'h0000FFFF, 32'h00000000, 32'h00000000, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        // count of zero acts as one
        '{0,    cli_pkg::OP_QUERY, 8'd0,   32'h40000000, 32'h00000000, 32'h00000000, 1'b1,
          TYPED, 32'h80000000, cli_pkg::CLAMP_FIRST},
        // widest possible span between two samples
        '{KEEP, cli_pkg::OP_LOAD,  8'd0,   32'h80000000, 32'h80000000, 32'h00000000, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_LOAD,  8'd1,   32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{2,    cli_pkg::OP_QUERY, 8'd0,   32'h7FFFFFFE, 32'h00000000, 32'h00000000, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_QUERY, 8'd0,   32'h00000000, 32'h00000000, 32'h00000000, 1'b1,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        // positions out of order: scan takes the first one above the query
        '{KEEP, cli_pkg::OP_LOAD,  8'd0,   32'h00000000, 32'h00010000, 32'hFFFF0000, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_LOAD,  8'd1,   32'h00020000, 32'h00030000, 32'h7FFF0000, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_LOAD,  8'd2,   32'h00010000, 32'hFFFFFFFF, 32'h00000001, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_LOAD,  8'd3,   32'h00030000, 32'h80000001, 32'h00001234, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{4,    cli_pkg::OP_QUERY, 8'd0,   32'h00018000, 32'h00000000, 32'h00000000, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_QUERY, 8'd0,   32'h00028000, 32'h00000000, 32'h00000000, 1'b1,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_QUERY, 8'd0,   32'h00020000, 32'h00000000, 32'h00000000, 1'b0,
          PREDICT, 32'h0, cli_pkg::CLAMP_INSIDE},
        '{KEEP, cli_pkg::OP_QUERY, 8'd0,   32'h00030000, 32'h00000000, 32'h00000000, 1'b1,
          TYPED, 32'h00001234, cli_pkg::CLAMP_LAST}
    };

    clamped_linear_interpolator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .index        (index),
        .position     (position),
        .value_x      (value_x),
        .value_y      (value_y),
        .component    (component),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .clamp_code   (clamp_code)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Interpolated component at a query position, with its clamp code
    function automatic result_t interpolate(input logic [31:0] q_raw, input logic second);
        result_t     res;
        int unsigned n;
        int unsigned last;
        int unsigned k;
        longint      q;
        longint      p0;
        longint      p1;
        longint      a;
        longint      b;
        longint      w;
        longint      blend;
        n = tbl_count;
        if (n == 0)
            n = 1;
        if (n > cli_pkg::SAMPLE_DEPTH)
            n = cli_pkg::SAMPLE_DEPTH;
        last = n - 1;
        q  = $signed(q_raw);
        p0 = $signed(tbl_pos[0]);
        p1 = $signed(tbl_pos[last]);
        if (n == 1 || q <= p0)
        begin
            res.value = second ? tbl_y[0] : tbl_x[0];
            res.code  = cli_pkg::CLAMP_FIRST;
        end
        else if (q >= p1)
        begin
            res.value = second ? tbl_y[last] : tbl_x[last];
            res.code  = cli_pkg::CLAMP_LAST;
        end
        else
        begin
            // first valid position strictly above the query
            k = 1;
            while (k < last && longint'($signed(tbl_pos[k])) <= q)
                k++;
            p0 = $signed(tbl_pos[k - 1]);
            p1 = $signed(tbl_pos[k]);
            a  = $signed(second ? tbl_y[k - 1] : tbl_x[k - 1]);
            b  = $signed(second ? tbl_y[k] : tbl_x[k]);
            w  = (p1 == p0) ? 0 : ((q - p0) <<< 16) / (p1 - p0);
            // round half toward plus infinity
            blend     = a + (((b - a) * w + 32768) >>> 16);
            res.value = blend[31:0];
            res.code  = cli_pkg::CLAMP_INSIDE;
        end
        return res;
    endfunction

    // Item taken by the block: update the table or queue its result
    function automatic void take_item(input item_t it);
        result_t res;
        if (it.op == cli_pkg::OP_LOAD)
        begin
            tbl_pos[it.index] = it.position;
            tbl_x[it.index]   = it.value_x;
            tbl_y[it.index]   = it.value_y;
        end
        else
        begin
            if (it.typed)
            begin
                res.value = it.exp_value;
                res.code  = it.exp_code;
            end
            else
            begin
                res = interpolate(it.position, it.component);
            end
            pending_results.insert(pending_results.size(), res);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(9) < 7)
            return $urandom;
        return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endfunction

    function automatic item_t random_payload();
        item_t it;
        it.op        = cli_pkg::OP_QUERY;
        it.index     = 8'($urandom);
        it.position  = $urandom;
        it.value_x   = pick_value();
        it.value_y   = pick_value();
        it.component = 1'($urandom);
        it.typed     = PREDICT;
        it.exp_value = '0;
        it.exp_code  = cli_pkg::CLAMP_INSIDE;
        return it;
    endfunction

    function automatic int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return 0;
        if (r < 12)
            return 1;
        if (r < 20)
            return 2;
        if (r < 25)
            return $urandom_range(255, 100);
        if (r < 28)
            return $urandom_range(511, 257);
        return $urandom_range(24, 3);
    endfunction

    task automatic queue_item(input item_t it);
        if (it.op == cli_pkg::OP_LOAD)
            plan_pos[it.index] = it.position;
        queued_items.insert(queued_items.size(), it);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (queued_items.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input int unsigned v);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data  <= v[cli_pkg::COUNT_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        tbl_count = v;
    endtask

    // Load entries 0..n-1, ascending unless a few are scrambled on purpose
    task automatic build_table(input int unsigned n, input int style_req);
        item_t       it;
        longint      p;
        longint      step_lo;
        longint      step_hi;
        int          style;
        int unsigned i;
        style = (style_req == STYLE_ANY) ? int'($urandom_range(2)) : style_req;
        p       = -longint'($urandom_range(32'h4000_0000));
        step_lo = 1;
        step_hi = 32'h0040_0000;
        if (style == STYLE_TIGHT)
        begin
            p       = longint'($signed($urandom)) >>> 1;
            step_lo = 1;
            step_hi = 3;
        end
        for (i = 0; i < n; i++)
        begin
            if (style == STYLE_FULL)
            begin
                if (n == 1)
                    p = longint'($signed($urandom));
                else
                    p = -longint'(32'h8000_0000)
                        + (longint'(i) * longint'(32'hFFFF_FFFF)) / longint'(n - 1);
            end
            else if (i != 0)
            begin
                // tight and spread layouts step upward
                if (style == STYLE_TIGHT || style == STYLE_SPREAD)
                    p += longint'($urandom_range(step_hi, step_lo));
            end
            plan_pos[i] = p[31:0];
        end
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(2, 1)) plan_pos[$urandom_range(n - 1)] = $urandom;
        for (i = 0; i < n; i++)
        begin
            it          = random_payload();
            it.op       = cli_pkg::OP_LOAD;
            it.index    = i[7:0];
            it.position = plan_pos[i];
            queue_item(it);
        end
    endtask

    // Query aimed mostly inside the table, some at samples, ends and beyond
    task automatic queue_query(input int unsigned n);
        item_t       it;
        longint      lo;
        longint      hi;
        longint      span;
        longint      q;
        int unsigned r;
        it   = random_payload();
        lo   = $signed(plan_pos[0]);
        hi   = $signed(plan_pos[n - 1]);
        span = hi - lo;
        r    = $urandom_range(99);
        q    = $signed(it.position);
        if (span > 0 && r >= 5)
        begin
            if (r < 65)
                q = lo + longint'({$urandom, $urandom} % (span + 1));
            else if (r < 80)
                q = longint'($signed(plan_pos[$urandom_range(n - 1)]))
                    + longint'($urandom_range(2)) - 1;
            else if (r < 90)
                q = lo - longint'($urandom_range(3));
            else
                q = hi + longint'($urandom_range(3));
        end
        it.position = q[31:0];
        queue_item(it);
    endtask

    // Single entry rewrite; inside the active range it mostly keeps its position
    task automatic queue_reload(input int unsigned n);
        item_t it;
        it       = random_payload();
        it.op    = cli_pkg::OP_LOAD;
        it.index = 8'($urandom_range(255));
        if (it.index < n && $urandom_range(9) != 0)
            it.position = plan_pos[it.index];
        queue_item(it);
    endtask

    // Input side: offer queued items, hold each until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                take_item(offered);
            if (!in_valid || in_ready)
            begin
                if (queued_items.size() != 0 && (no_idle || $urandom_range(99) >= 25))
                begin
                    offered   = queued_items.pop_front();
                    in_valid  <= 1'b1;
                    op        <= offered.op;
                    index     <= offered.index;
                    position  <= offered.position;
                    value_x   <= offered.value_x;
                    value_y   <= offered.value_y;
                    component <= offered.component;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stalls, compare each result with the oldest expected one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with nothing pending", result_value, '0);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (result_value !== oldest.value)
                        report_mismatch("result_value", result_value, oldest.value);
                    if (clamp_code !== oldest.code)
                        report_mismatch("clamp_code", {30'b0, clamp_code}, {30'b0, oldest.code});
                end
            end
            out_ready <= !hold_off && (no_idle || $urandom_range(99) >= 25);
        end
    end

    // Long receiver hold-off so the block fills and stalls its input
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog on cycles with no item taken on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Main sequence
    initial
    begin
        item_t       it;
        int unsigned phase;
        int unsigned cnt;
        int unsigned n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].new_count != KEEP)
                write_count(directed_rows[r].new_count);
            it.op        = directed_rows[r].op;
            it.index     = directed_rows[r].index;
            it.position  = directed_rows[r].position;
            it.value_x   = directed_rows[r].value_x;
            it.value_y   = directed_rows[r].value_y;
            it.component = directed_rows[r].component;
            it.typed     = directed_rows[r].typed;
            it.exp_value = directed_rows[r].exp_value;
            it.exp_code  = directed_rows[r].exp_code;
            queue_item(it);
        end

        // random phases: new count, a fresh table (none in phase 1), then a burst of queries and rewrites
        items_queued = 0;
        phase        = 0;
        while (items_queued < RANDOM_ITEMS)
        begin
            if (phase == 0)
                cnt = 511;
            else if (phase == 1)
                cnt = cli_pkg::SAMPLE_DEPTH;
            else
                cnt = pick_count();
            write_count(cnt);
            no_idle <= (phase == 3);
            n = (cnt == 0) ? 1 : ((cnt > cli_pkg::SAMPLE_DEPTH) ? cli_pkg::SAMPLE_DEPTH : cnt);
            if (phase == 0)
                build_table(n, STYLE_FULL);
            else if (phase != 1)
                build_table(n, STYLE_ANY);
            repeat ($urandom_range(120, 40))
            begin
                if ($urandom_range(99) < 85)
                    queue_query(n);
                else
                    queue_reload(n);
            end
            if (phase == 5)
                pressure_go <= 1'b1;
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
